[rtl/prq_pkg.sv]
`timescale 1ns / 1ps
package prq_pkg;
  localparam int NumThreads = 32;
  localparam int NumPrios   = 32;
  localparam int TidW = 5;
  localparam int PriW = 5;
  localparam int CntW = 6;

  typedef enum logic [1:0] {
    REQ_ADD   = 2'd0,
    REQ_DEL   = 2'd1,
    REQ_SCHED = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DUP     = 2'd1,
    ST_NOTQ    = 2'd2,
    ST_NOREADY = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_SCHED,
    S_OUT
  } state_t;

  // request to the bitmap search unit
  typedef struct packed {
    logic start;
  } scan_req_t;

  typedef struct packed {
    logic            done;
    logic            found;
    logic [PriW-1:0] prio;
  } scan_rsp_t;
endpackage

[rtl/priority_ready_queue_scheduler_core.sv]
`timescale 1ns / 1ps
// Hardware ready queue: one FIFO per priority as linked lists over thread
// slots, plus a bitmap of non-empty priorities.
// in_ channel: one request transaction (add, delete, schedule).
// out_ channel: exactly one result transaction per request.
// Add, delete and no-op: out_tvalid follows acceptance after a registered
// read of the link and list tables (S_READ) and the write-back step (S_EXEC).
// Schedule walks the bitmap eight bits per cycle in the search unit after the
// read step (S_SCAN); S_SCHED then takes the head of the lowest non-empty
// priority as running thread, and is skipped when nothing is ready.
// in_tready is high only in idle; a new request is taken once the previous
// result has been taken, so a stalled receiver holds the block.
// Reset clears bitmap, queued bits, count, pending flag and running thread;
// the link tables need no clearing since they are only read when valid.
module priority_ready_queue_scheduler_core
  import prq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // req_type[1:0], thread_id[6:2], priority_req[11:7]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata  // status, chosen_thread, prev_thread, switch_needed,
                                 // ready_count, sched_pending
);
  state_t state_r, state_nxt;

  logic [NumPrios-1:0]   bitmap_r;
  logic [NumThreads-1:0] queued_r;
  logic [TidW-1:0]       run_r;
  logic [CntW-1:0]       count_r;
  logic                  pend_r;

  logic [TidW-1:0] head_m [NumPrios];
  logic [TidW-1:0] tail_m [NumPrios];
  logic [TidW-1:0] next_m [NumThreads];
  logic [TidW-1:0] prev_m [NumThreads];
  logic [PriW-1:0] prio_m [NumThreads];

  req_t            req_r;
  logic [TidW-1:0] tid_r;
  logic [PriW-1:0] pri_r;
  // read data
  logic [PriW-1:0] sp_r;
  logic [TidW-1:0] nx_r, pv_r;
  logic [TidW-1:0] hd_r, tl_r;

  status_t         st_r;
  logic [TidW-1:0] prevrun_r;
  logic            sw_r;

  scan_req_t sreq;
  scan_rsp_t srsp;

  prq_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (sreq),
    .bitmap (bitmap_r),
    .rsp    (srsp)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {4'd0, pend_r, count_r, sw_r, prevrun_r, run_r, st_r};

  always_comb begin
    state_nxt = state_r;
    sreq.start = 1'b0;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_READ;
      S_READ: begin
        if (req_r == REQ_SCHED) begin
          sreq.start = 1'b1;
          state_nxt  = S_SCAN;
        end else begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC:  state_nxt = S_OUT;
      S_SCAN:  if (srsp.done) state_nxt = srsp.found ? S_SCHED : S_OUT;
      S_SCHED: state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // table reads, registered
  logic [PriW-1:0] rp;
  assign rp = (req_r == REQ_ADD) ? pri_r : prio_m[tid_r];
  logic [TidW-1:0] rd_hd;

  always_ff @(posedge clk) begin
    if (state_r == S_READ) begin
      sp_r <= rp;
      nx_r <= next_m[tid_r];
      pv_r <= prev_m[tid_r];
      hd_r <= head_m[rp];
      tl_r <= tail_m[rp];
    end
    if (state_r == S_SCAN) hd_r <= head_m[srsp.prio];
  end
  assign rd_hd = hd_r;

  // list writes, one step
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && req_r == REQ_ADD && !queued_r[tid_r]) begin
      prio_m[tid_r] <= sp_r;
      tail_m[sp_r]  <= tid_r;
      next_m[tid_r] <= tid_r;
      if (bitmap_r[sp_r]) begin
        next_m[tl_r]  <= tid_r;
        prev_m[tid_r] <= tl_r;
      end else begin
        head_m[sp_r]  <= tid_r;
        prev_m[tid_r] <= tid_r;
      end
    end
    if (state_r == S_EXEC && req_r == REQ_DEL && queued_r[tid_r]
        && !(hd_r == tid_r && tl_r == tid_r)) begin
      if (hd_r == tid_r) head_m[sp_r] <= nx_r;
      else               next_m[pv_r] <= nx_r;
      if (tl_r == tid_r) tail_m[sp_r] <= pv_r;
      else               prev_m[nx_r] <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      bitmap_r <= '0;
      queued_r <= '0;
      run_r    <= '0;
      count_r  <= '0;
      pend_r   <= 1'b0;
      st_r     <= ST_OK;
      sw_r     <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            prevrun_r <= run_r;
            sw_r      <= 1'b0;
            st_r      <= ST_OK;
            if (in_tdata[11:7] >= PriW'(NumPrios - 1)) pri_r <= PriW'(NumPrios - 1);
            else                                        pri_r <= in_tdata[11:7];
          end
        end
        S_EXEC: begin
          if (req_r == REQ_ADD) begin
            if (queued_r[tid_r]) st_r <= ST_DUP;
            else begin
              queued_r[tid_r] <= 1'b1;
              bitmap_r[sp_r]  <= 1'b1;
              count_r         <= count_r + 1'b1;
              pend_r          <= 1'b1;
            end
          end else if (req_r == REQ_DEL) begin
            if (!queued_r[tid_r]) st_r <= ST_NOTQ;
            else begin
              queued_r[tid_r] <= 1'b0;
              if (hd_r == tid_r && tl_r == tid_r) bitmap_r[sp_r] <= 1'b0;
              if (count_r != '0) count_r <= count_r - 1'b1;
              pend_r <= 1'b1;
            end
          end
        end
        S_SCAN: begin
          if (srsp.done) begin
            pend_r <= 1'b0;
            if (!srsp.found) st_r <= ST_NOREADY;
          end
        end
        S_SCHED: begin
          sw_r  <= (rd_hd != run_r);
          run_r <= rd_hd;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_tvalid) begin
      req_r <= req_t'(in_tdata[1:0]);
      tid_r <= in_tdata[6:2];
    end
  end
endmodule

[rtl/prq_scan.sv]
`timescale 1ns / 1ps
// Lowest-set-bit search, eight bits per cycle.
module prq_scan
  import prq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  scan_req_t            req,
  input  logic [NumPrios-1:0]  bitmap,
  output scan_rsp_t            rsp
);
  localparam int Chunks = NumPrios / 8;
  localparam int ChW = (Chunks > 1) ? $clog2(Chunks) : 1;

  logic          busy_r, busy_nxt;
  logic [ChW-1:0] idx_r, idx_nxt;
  logic [7:0]    chunk;
  logic          hit;
  logic [2:0]    pos;
  scan_rsp_t     rsp_r, rsp_nxt;

  always_comb begin
    chunk = bitmap[{idx_r, 3'b000} +: 8];
    hit = |chunk;
    pos = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (chunk[i]) pos = 3'(i);
    end
  end

  always_comb begin
    busy_nxt = busy_r;
    idx_nxt  = idx_r;
    rsp_nxt  = '0;
    if (req.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = '0;
    end else if (busy_r) begin
      if (hit || idx_r == ChW'(Chunks - 1)) begin
        busy_nxt      = 1'b0;
        rsp_nxt.done  = 1'b1;
        rsp_nxt.found = hit;
        rsp_nxt.prio  = PriW'({idx_r, pos});
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
      rsp_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
      rsp_r  <= rsp_nxt;
    end
  end

  assign rsp = rsp_r;
endmodule
